// ===== src/lsb_first_bit_packer_macros.svh =====
// Assertion helpers used by the top-level packer, the only block that checks itself.
`ifndef LSB_FIRST_BIT_PACKER_MACROS_SVH
`define LSB_FIRST_BIT_PACKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lbp_pkg.sv =====
`timescale 1ns / 1ps
package lbp_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] MAX_BYTES_RESET = 16'd1024;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RESTART  = 2'd1,
    ST_DENIED   = 2'd2,
    ST_TOO_WIDE = 2'd3
  } status_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_ALIGN = 1'b1
  } op_t;

  typedef enum logic {
    CFG_MAX_BYTES = 1'b0,
    CFG_ALLOW_OVF = 1'b1
  } cfg_index_t;

  // One input's results: up to four completed bytes and the shared status.
  typedef struct packed {
    logic            has_bytes;
    logic [1:0]      last_beat;
    logic [3:0][7:0] bytes;
    status_t         status;
    logic            warn;
    logic            restart;
    logic            ovf;
  } entry_t;

endpackage

// ===== src/lbp_front.sv =====
`timescale 1ns / 1ps
module lbp_front import lbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [31:0] value,
  input  logic [5:0]  width,
  input  logic        is_signed,
  input  logic        queue_ready,
  output logic        push,
  output entry_t      entry
);

  logic [15:0] max_bytes;
  logic        allow_ovf;
  logic [7:0]  pending, pending_next;
  logic [2:0]  bit_pos, bit_pos_next;
  logic [15:0] bytes_done, bytes_done_next;
  logic        ovf_mark, ovf_mark_next;

  assign in_ready = queue_ready;
  assign push = in_valid & queue_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MAX_BYTES_RESET;
      allow_ovf <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_MAX_BYTES: max_bytes <= cfg_data;
        CFG_ALLOW_OVF: allow_ovf <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      bit_pos <= '0;
      bytes_done <= '0;
      ovf_mark <= 1'b0;
    end else if (push) begin
      pending <= pending_next;
      bit_pos <= bit_pos_next;
      bytes_done <= bytes_done_next;
      ovf_mark <= ovf_mark_next;
    end
  end

  always_comb begin
    logic        bad_width;
    logic        full_width;
    logic [4:0]  n5;
    logic [4:0]  nm1;
    logic [31:0] mask;
    logic [31:0] hi;
    logic        unsigned_oor;
    logic        signed_oor;
    logic        range_bad;
    logic [18:0] cap;
    logic [19:0] need;
    logic        over;
    logic        too_wide;
    logic [39:0] acc;
    logic [5:0]  total;
    logic [2:0]  nbytes;

    bad_width = (width == 6'd0) || (width > 6'd32);
    full_width = width[5];
    n5 = width[4:0];
    nm1 = n5 - 5'd1;
    mask = full_width ? 32'hFFFF_FFFF : ((32'd1 << n5) - 32'd1);
    unsigned_oor = (value >> n5) != 32'd0;
    hi = value >> nm1;
    signed_oor = !((hi == 32'd0) || (hi == (32'hFFFF_FFFF >> nm1)));
    range_bad = !full_width && (is_signed ? signed_oor : unsigned_oor);
    cap = {max_bytes, 3'b000};
    need = {14'd0, width} + {1'b0, bytes_done, bit_pos};
    over = need > {1'b0, cap};
    too_wide = {13'd0, width} > cap;
    acc = {32'd0, pending} | ({8'd0, value & mask} << bit_pos);
    total = {3'd0, bit_pos} + width;
    nbytes = total[5:3];

    pending_next = pending;
    bit_pos_next = bit_pos;
    bytes_done_next = bytes_done;
    ovf_mark_next = ovf_mark;
    entry.has_bytes = 1'b0;
    entry.last_beat = 2'd0;
    entry.bytes = acc[31:0];
    entry.status = ST_OK;
    entry.warn = 1'b0;
    entry.restart = 1'b0;
    entry.ovf = ovf_mark;

    if (op_t'(op) == OP_ALIGN) begin
      if (bit_pos != 3'd0) begin
        entry.has_bytes = 1'b1;
        entry.bytes = {24'd0, pending};
        pending_next = '0;
        bit_pos_next = '0;
        bytes_done_next = bytes_done + 16'd1;
      end
    end else if (bad_width) begin
      entry.warn = 1'b1;
    end else begin
      entry.warn = range_bad;
      if (over) begin
        if (!allow_ovf) begin
          entry.status = ST_DENIED;
        end else if (too_wide) begin
          entry.status = ST_TOO_WIDE;
        end else begin
          pending_next = '0;
          bit_pos_next = '0;
          bytes_done_next = '0;
          ovf_mark_next = 1'b1;
          entry.status = ST_RESTART;
          entry.restart = 1'b1;
          entry.ovf = 1'b1;
        end
      end else begin
        entry.has_bytes = nbytes != 3'd0;
        entry.last_beat = entry.has_bytes ? 2'(nbytes - 3'd1) : 2'd0;
        case (nbytes)
          3'd0: pending_next = acc[7:0];
          3'd1: pending_next = acc[15:8];
          3'd2: pending_next = acc[23:16];
          3'd3: pending_next = acc[31:24];
          default: pending_next = acc[39:32];
        endcase
        bit_pos_next = total[2:0];
        bytes_done_next = bytes_done + {13'd0, nbytes};
      end
    end
  end

endmodule

// ===== src/lbp_queue.sv =====
`timescale 1ns / 1ps
module lbp_queue import lbp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t din,
  output logic   ready,
  output logic   valid,
  output entry_t dout,
  input  logic   pop
);

  entry_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign ready = count != QCNT_W'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign dout = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== src/lbp_back.sv =====
`timescale 1ns / 1ps
module lbp_back import lbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  entry_t      head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_data,
  output logic        out_user,
  output logic        out_last
);

  logic [1:0] beat;
  logic [7:0] cur_byte;

  assign out_valid = q_valid;
  assign cur_byte = head.has_bytes ? head.bytes[beat] : 8'd0;
  assign out_last = !head.has_bytes || (beat == head.last_beat);
  assign out_user = head.has_bytes;
  assign out_data = {3'd0, head.ovf, head.restart, head.warn, head.status, cur_byte};
  assign q_pop = out_valid && out_ready && out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat <= '0;
    end else if (out_valid && out_ready) begin
      beat <= out_last ? 2'd0 : beat + 2'd1;
    end
  end

endmodule

// ===== src/lsb_first_bit_packer.sv =====
// Packs fields of 1 to 32 bits, least significant bit first, into bytes.
// The s_axis channel takes one operation per beat: write a field or align
// and flush the zero-padded partial byte. Every input yields one to four
// beats on m_axis, one per completed byte, or a single status beat with
// tuser low when no byte completes; tlast marks the last beat of an input.
// Results leave in input order, and the first beat of an input appears
// the cycle after it is accepted when the queue is empty.
// Inputs completing at most one byte sustain one input per cycle while
// tready is high; one completing k bytes holds the output for k beats,
// and a four-entry queue between the classifier and the byte emitter
// absorbs bursts, so s_axis stalls only once four inputs wait to drain.
// A receiver stall holds the current beat and lets the queue fill.
// The cfg channel writes max_message_bytes (index 0) and allow_overflow
// (index 1); it is always ready and must be used only while idle.
// Reset clears the partial byte, bit position, byte count, overflow mark
// and queue, and restores a capacity of 1024 bytes with overflow denied.
`timescale 1ns / 1ps
`include "lsb_first_bit_packer_macros.svh"
module lsb_first_bit_packer import lbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // field_value[31:0], field_width[37:32], is_signed[38], zero[39].
  input  logic [39:0] s_axis_tdata,
  // operation[0].
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte[7:0], status[9:8], range_warning[10], message_restarted[11],
  // overflowed[12], zero[15:13].
  output logic [15:0] m_axis_tdata,
  // byte_valid[0].
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  logic   push;
  logic   q_ready;
  logic   q_valid;
  logic   q_pop;
  entry_t front_entry;
  entry_t head;

  assign cfg_ready = 1'b1;

  lbp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .op          (s_axis_tuser[0]),
    .value       (s_axis_tdata[31:0]),
    .width       (s_axis_tdata[37:32]),
    .is_signed   (s_axis_tdata[38]),
    .queue_ready (q_ready),
    .push        (push),
    .entry       (front_entry)
  );

  lbp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_entry),
    .ready (q_ready),
    .valid (q_valid),
    .dout  (head),
    .pop   (q_pop)
  );

  lbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (head),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser[0]),
    .out_last  (m_axis_tlast)
  );

  `LBP_ASSERT_SAME(a_status_beat_is_last, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast, "status beat without tlast")
  `LBP_ASSERT_SAME(a_error_has_no_byte, m_axis_tvalid && (m_axis_tdata[9:8] != ST_OK), !m_axis_tuser[0] && (m_axis_tdata[7:0] == 8'd0), "byte emitted with error status")
  `LBP_ASSERT_SAME(a_restart_marks_ovf, m_axis_tvalid && m_axis_tdata[11], m_axis_tdata[12] && (m_axis_tdata[9:8] == ST_RESTART), "restart without overflow mark")
  `LBP_ASSERT_NEXT(a_overflow_sticky, m_axis_tvalid && m_axis_tready && m_axis_tdata[12], !m_axis_tvalid || m_axis_tdata[12], "overflow mark dropped")

endmodule

// ===== sim/tb_lsb_first_bit_packer.sv =====
`timescale 1ns / 1ps
module tb_lsb_first_bit_packer;
  import lbp_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    op_t         op;
    logic [31:0] value;
    logic [5:0]  width;
    logic        sgn;
  } field_cmd_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data;
    status_t    status;
    logic       warn;
    logic       restart;
    logic       ovf;
    logic       last;
  } byte_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = 40'd0;
  logic [0:0]  s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;

  lsb_first_bit_packer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk = ~clk;

  field_cmd_t cmd_q[$];
  byte_beat_t bytes_due[$];

  logic [15:0] cap_bytes = MAX_BYTES_RESET;
  logic        allow_ovf = 1'b0;
  logic [7:0]  pend_byte = 8'd0;
  logic [2:0]  bit_pos = 3'd0;
  logic [15:0] byte_count = 16'd0;
  logic        ovf_mark = 1'b0;

  logic send_idle = 1'b1;
  logic recv_idle = 1'b1;
  logic hold_req = 1'b0;
  int   mismatch_count = 0;
  int   cmds_taken = 0;
  int   beats_seen = 0;
  int   restarts_seen = 0;
  int   quiet_cycles = 0;

  function automatic logic misfits(logic [31:0] v, logic [5:0] n, logic sgn);
    logic [31:0] top;
    if (n >= 6'd32) return 1'b0;
    if (!sgn) return (v >> n) != 32'd0;
    top = v >> (n - 1);
    return !(top == 32'd0 || top == (32'hFFFF_FFFF >> (n - 1)));
  endfunction

  function automatic byte_beat_t make_beat(logic valid, logic [7:0] data, status_t st,
                                           logic warn, logic restart, logic ovf);
    byte_beat_t b;
    b.byte_valid = valid;
    b.data = data;
    b.status = st;
    b.warn = warn;
    b.restart = restart;
    b.ovf = ovf;
    b.last = 1'b0;
    return b;
  endfunction

  task automatic predict_bytes(input field_cmd_t c);
    byte_beat_t beats[$];
    logic [63:0] acc;
    int room;
    int total;
    logic warn;
    logic restart;
    status_t st;
    warn = 1'b0;
    restart = 1'b0;
    st = ST_OK;
    if (c.op == OP_ALIGN) begin
      if (bit_pos != 3'd0) begin
        beats.push_back(make_beat(1'b1, pend_byte, ST_OK, 1'b0, 1'b0, ovf_mark));
        byte_count = byte_count + 16'd1;
        pend_byte = 8'd0;
        bit_pos = 3'd0;
      end
    end else if (c.width == 6'd0 || c.width > 6'd32) begin
      warn = 1'b1;
    end else begin
      warn = misfits(c.value, c.width, c.sgn);
      room = int'(cap_bytes) * 8 - (int'(byte_count) * 8 + int'(bit_pos));
      if (int'(c.width) > room) begin
        if (!allow_ovf) begin
          st = ST_DENIED;
        end else if (int'(c.width) > int'(cap_bytes) * 8) begin
          st = ST_TOO_WIDE;
        end else begin
          pend_byte = 8'd0;
          bit_pos = 3'd0;
          byte_count = 16'd0;
          ovf_mark = 1'b1;
          st = ST_RESTART;
          restart = 1'b1;
        end
      end else begin
        acc = ((64'(c.value) & ((64'd1 << c.width) - 64'd1)) << bit_pos) | 64'(pend_byte);
        total = int'(bit_pos) + int'(c.width);
        while (total >= 8) begin
          beats.push_back(make_beat(1'b1, acc[7:0], ST_OK, warn, 1'b0, ovf_mark));
          byte_count = byte_count + 16'd1;
          acc = acc >> 8;
          total -= 8;
        end
        pend_byte = acc[7:0];
        bit_pos = total[2:0];
      end
    end
    if (beats.size() == 0) beats.push_back(make_beat(1'b0, 8'h00, st, warn, restart, ovf_mark));
    beats[beats.size() - 1].last = 1'b1;
    foreach (beats[i]) bytes_due.push_back(beats[i]);
  endtask

  // Driver: offers queued commands, with random gaps between beats while send_idle is set.
  always @(posedge clk) begin
    logic busy;
    int gap_left;
    field_cmd_t cur;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_bytes(cur);
        cmds_taken++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (send_idle && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 11);
        end else if (cmd_q.size() > 0) begin
          cur = cmd_q.pop_front();
          s_axis_tdata <= {1'b0, cur.sgn, cur.width, cur.value};
          s_axis_tuser <= cur.op;
          busy = 1'b1;
        end
      end
      s_axis_tvalid <= busy;
    end
  end

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: checks each output beat and drives tready, including one long hold-off.
  always @(posedge clk) begin
    byte_beat_t want;
    logic rdy;
    logic hold_done;
    int hold_left;
    int stall_left;
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_done = 1'b0;
      hold_left = 0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        beats_seen++;
        if (bytes_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual tdata 0x%0h tuser %0b",
                   $time, m_axis_tdata, m_axis_tuser);
          mismatch_count++;
        end else begin
          want = bytes_due.pop_front();
          if (want.restart) restarts_seen++;
          check_field("byte_valid", want.byte_valid, m_axis_tuser[0]);
          check_field("out_byte", want.data, m_axis_tdata[7:0]);
          check_field("status", want.status, m_axis_tdata[9:8]);
          check_field("range_warning", want.warn, m_axis_tdata[10]);
          check_field("message_restarted", want.restart, m_axis_tdata[11]);
          check_field("overflowed", want.ovf, m_axis_tdata[12]);
          check_field("last", want.last, m_axis_tlast);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (recv_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 11);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      m_axis_tready <= rdy;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d beats still due", $time, QUIET_LIMIT,
               bytes_due.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MAX_BYTES: cap_bytes = value;
      CFG_ALLOW_OVF: allow_ovf = value[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_q.size() != 0 || s_axis_tvalid || bytes_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic configure(input logic [15:0] cap, input logic allow);
    wait_drained();
    write_reg(CFG_MAX_BYTES, cap);
    write_reg(CFG_ALLOW_OVF, {15'd0, allow});
    @(negedge clk);
  endtask

  task automatic queue_cmd(input op_t op, input logic [31:0] value, input logic [5:0] width,
                           input logic sgn);
    field_cmd_t c;
    c.op = op;
    c.value = value;
    c.width = width;
    c.sgn = sgn;
    cmd_q.push_back(c);
  endtask

  // Mostly well-formed writes with in-range values; some aligns, bad widths and wild values.
  task automatic queue_random(input int count);
    logic [31:0] raw;
    logic [31:0] mask;
    logic [5:0]  n;
    logic        sgn;
    int          pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      raw = $urandom;
      sgn = $urandom_range(0, 1);
      if (pick < 12) begin
        queue_cmd(OP_ALIGN, raw, 6'($urandom_range(0, 63)), sgn);
      end else if (pick < 18) begin
        n = ($urandom_range(0, 3) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
        queue_cmd(OP_WRITE, raw, n, sgn);
      end else begin
        pick = $urandom_range(0, 3);
        n = (pick < 2) ? 6'($urandom_range(1, 8)) :
            (pick == 2) ? 6'($urandom_range(9, 24)) : 6'($urandom_range(25, 32));
        if ($urandom_range(0, 4) != 0) begin
          mask = (n == 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
          raw = (sgn && raw[n - 1]) ? (raw | ~mask) : (raw & mask);
        end
        queue_cmd(OP_WRITE, raw, n, sgn);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    configure(16'd1024, 1'b0);
    queue_cmd(OP_WRITE, 32'h0000_0001, 6'd1, 1'b0);
    queue_cmd(OP_WRITE, 32'h0000_007F, 6'd7, 1'b0);
    queue_cmd(OP_WRITE, 32'hFFFF_FFFF, 6'd32, 1'b0);
    queue_cmd(OP_WRITE, 32'h0000_0000, 6'd3, 1'b0);
    queue_cmd(OP_WRITE, 32'hFFFF_FFFF, 6'd32, 1'b1);
    queue_cmd(OP_WRITE, 32'h8000_0000, 6'd32, 1'b1);
    queue_cmd(OP_WRITE, 32'h0000_0100, 6'd8, 1'b0);
    queue_cmd(OP_WRITE, 32'h0000_0080, 6'd8, 1'b1);
    queue_cmd(OP_WRITE, 32'hFFFF_FF80, 6'd8, 1'b1);
    queue_cmd(OP_WRITE, 32'h1234_5678, 6'd0, 1'b0);
    queue_cmd(OP_WRITE, 32'h1234_5678, 6'd33, 1'b1);
    queue_cmd(OP_WRITE, 32'hFFFF_FFFF, 6'd63, 1'b1);
    queue_cmd(OP_ALIGN, 32'h0000_0000, 6'd0, 1'b0);
    queue_cmd(OP_ALIGN, 32'hFFFF_FFFF, 6'd63, 1'b1);
    queue_cmd(OP_WRITE, 32'h0000_0055, 6'd7, 1'b0);
    queue_cmd(OP_WRITE, 32'hDEAD_BEEF, 6'd32, 1'b0);
    queue_cmd(OP_ALIGN, 32'h0000_0000, 6'd1, 1'b0);

    // The byte count already exceeds the new capacity, so the write is denied.
    configure(16'd1, 1'b0);
    queue_cmd(OP_WRITE, 32'h0000_0001, 6'd1, 1'b0);

    configure(16'd2, 1'b1);
    queue_cmd(OP_WRITE, 32'h0000_01FF, 6'd9, 1'b0);
    queue_cmd(OP_WRITE, 32'h0000_0ABC, 6'd12, 1'b0);
    queue_cmd(OP_WRITE, 32'h0000_0015, 6'd5, 1'b0);
    queue_cmd(OP_WRITE, 32'h0001_0000, 6'd17, 1'b0);
    queue_cmd(OP_WRITE, 32'h0000_00FF, 6'd16, 1'b0);

    configure(16'd1, 1'b0);
    queue_cmd(OP_WRITE, 32'h0000_0000, 6'd1, 1'b1);

    configure(16'd4, 1'b1);
    hold_req = 1'b1;
    queue_random(50);

    configure(16'hFFFF, 1'b0);
    queue_random(50);

    configure(16'd3, 1'b0);
    queue_random(20);

    configure(16'd6, 1'b1);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    queue_random(66);

    wait_drained();
    repeat (12) @(negedge clk);
    $display("Checked %0d output beats from %0d commands over eight register settings,",
             beats_seen, cmds_taken);
    $display("with %0d message restarts and a %0d-cycle receiver hold-off.",
             restarts_seen, HOLD_CYCLES);
    if (mismatch_count == 0 && bytes_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
